// ===== src/dkgs_pkg.sv =====
package dkgs_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned GearW   = 2;
  localparam int unsigned InW     = 8;
  localparam int unsigned OutW    = 8;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD  = 2'd0,
    REG_DEBOUNCE_COUNT = 2'd1,
    REG_GEAR_COUNT     = 2'd2,
    REG_INITIAL_GEAR   = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_PRESS_WAIT      = 6'b000001,
    PH_PRESS_DELAY     = 6'b000010,
    PH_PRESS_CONFIRM   = 6'b000100,
    PH_RELEASE_WAIT    = 6'b001000,
    PH_RELEASE_DELAY   = 6'b010000,
    PH_RELEASE_CONFIRM = 6'b100000
  } key_phase_t;

  typedef struct packed {
    logic [PeriodW-1:0] sample_period;
    logic [CountW-1:0]  debounce_count;
    logic [GearW-1:0]   gear_count;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [GearW-1:0] value;
  } gear_load_t;

  typedef struct packed {
    logic [GearW-1:0] heat_gear;
    logic             gear_changed;
  } result_t;

  function automatic logic [GearW-1:0] eff_gears(input logic [GearW-1:0] cnt);
    eff_gears = (cnt == '0) ? GearW'(1) : cnt;
  endfunction

  function automatic logic [GearW-1:0] clamp_gear(input logic [GearW-1:0] g,
                                                  input logic [GearW-1:0] cnt);
    logic [GearW-1:0] n;
    n = eff_gears(cnt);
    clamp_gear = (g >= n) ? n - GearW'(1) : g;
  endfunction

endpackage

// ===== src/debounced_key_gear_selector_unit.sv =====
// A result beat appears in the cycle after its tick beat is taken.
// Throughput: one tick per cycle; the next tick is taken in the same cycle
// as the waiting result is taken, set by the single output register.
// Reset (rst_n low, synchronous): registers back to 10/10/3, gear 0,
// prescaler and debounce count 0, key machine waiting for a press.
module debounced_key_gear_selector_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dkgs_pkg::InW-1:0]   in_tdata,   // [0] key_level, [1] fan_running
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dkgs_pkg::OutW-1:0]  out_tdata,  // [1:0] heat_gear, [2] gear_changed
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data
);
  import dkgs_pkg::*;

  cfg_t       cfg_r;
  gear_load_t gear_load;
  result_t    res, res_r;
  key_phase_t phase;
  logic       out_valid_r;
  logic       in_fire, cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period  <= PeriodW'(10);
      cfg_r.debounce_count <= CountW'(10);
      cfg_r.gear_count     <= GearW'(3);
    end else if (cfg_fire) begin
      case (reg_idx_t'(cfg_index))
        REG_SAMPLE_PERIOD:  cfg_r.sample_period  <= cfg_data[PeriodW-1:0];
        REG_DEBOUNCE_COUNT: cfg_r.debounce_count <= cfg_data[CountW-1:0];
        REG_GEAR_COUNT:     cfg_r.gear_count     <= cfg_data[GearW-1:0];
        default: ;
      endcase
    end
  end

  // initial gear goes straight into the gear register, clamped to range
  assign gear_load.load  = cfg_fire && (reg_idx_t'(cfg_index) == REG_INITIAL_GEAR);
  assign gear_load.value = clamp_gear(cfg_data[GearW-1:0], cfg_r.gear_count);

  dkgs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .key_level   (in_tdata[0]),
    .fan_running (in_tdata[1]),
    .cfg         (cfg_r),
    .gear_load   (gear_load),
    .res         (res),
    .phase       (phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutW-GearW-1){1'b0}}, res_r.gear_changed, res_r.heat_gear};

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase))
    else $error("key phase not one-hot");

  a_fan_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tdata[1] |=> out_tdata[2:0] == 3'b000)
    else $error("gear reported while fan stopped");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("gear out of range");

  a_change_needs_fan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.gear_changed |-> in_tdata[1])
    else $error("gear advanced without fan running");
`endif

endmodule

// ===== src/dkgs_core.sv =====
module dkgs_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     key_level,
  input  logic                     fan_running,
  input  dkgs_pkg::cfg_t           cfg,
  input  dkgs_pkg::gear_load_t     gear_load,
  output dkgs_pkg::result_t        res,
  output dkgs_pkg::key_phase_t     phase
);
  import dkgs_pkg::*;

  logic [PeriodW-1:0] tick_r, tick_nxt, tick_dec;
  key_phase_t         phase_r, phase_nxt;
  logic [CountW-1:0]  left_r, left_nxt, left_dec;
  logic [GearW-1:0]   gear_r, gear_nxt;
  logic [GearW:0]     gear_inc;
  logic               sample, pressed, changed;

  assign tick_dec = (tick_r == '0) ? '0 : tick_r - PeriodW'(1);
  assign left_dec = (left_r == '0) ? '0 : left_r - CountW'(1);
  assign sample   = fan_running && (tick_dec == '0);
  assign pressed  = !key_level;
  assign gear_inc = {1'b0, gear_r} + (GearW+1)'(1);

  always_comb begin
    tick_nxt  = tick_dec;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    gear_nxt  = gear_r;
    changed   = 1'b0;
    if (sample) begin
      tick_nxt = cfg.sample_period;
      case (phase_r)
        PH_PRESS_WAIT: begin
          if (pressed) begin
            phase_nxt = PH_PRESS_DELAY;
            left_nxt  = cfg.debounce_count;
          end
        end
        PH_PRESS_DELAY: begin
          left_nxt = left_dec;
          if (!pressed)             phase_nxt = PH_PRESS_WAIT;
          else if (left_dec == '0)  phase_nxt = PH_PRESS_CONFIRM;
        end
        PH_PRESS_CONFIRM: phase_nxt = PH_RELEASE_WAIT;
        PH_RELEASE_WAIT: begin
          if (!pressed) begin
            phase_nxt = PH_RELEASE_DELAY;
            left_nxt  = cfg.debounce_count;
          end
        end
        PH_RELEASE_DELAY: begin
          left_nxt = left_dec;
          if (pressed)              phase_nxt = PH_RELEASE_WAIT;
          else if (left_dec == '0)  phase_nxt = PH_RELEASE_CONFIRM;
        end
        PH_RELEASE_CONFIRM: begin
          // wrap when stepping past the last gear
          gear_nxt  = (gear_inc >= {1'b0, eff_gears(cfg.gear_count)}) ? '0
                                                                     : gear_inc[GearW-1:0];
          changed   = 1'b1;
          phase_nxt = PH_PRESS_WAIT;
        end
        default: phase_nxt = PH_PRESS_WAIT;
      endcase
    end
  end

  always_comb begin
    res.heat_gear    = fan_running ? gear_nxt : '0;
    res.gear_changed = changed;
  end

  assign phase = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      phase_r <= PH_PRESS_WAIT;
      left_r  <= '0;
      gear_r  <= '0;
    end else if (gear_load.load) begin
      gear_r <= gear_load.value;
    end else if (step) begin
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      gear_r  <= gear_nxt;
    end
  end

endmodule
